FILE: hdl/impq_pkg.sv
// ----------------------------------------------------------------------------
// impq_pkg
// Shared types and constants for the indexed max priority queue core.
// ----------------------------------------------------------------------------
package impq_pkg;

    // field widths fixed by the stream words
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 7;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 88;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHANGE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_GET     = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OCCUPIED = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_EX_ORD,
        S_EX_KEY,
        S_EX_LK,
        S_UP,
        S_UP_O,
        S_UP_K,
        S_DN,
        S_DN_L,
        S_DN_LK,
        S_DN_RK,
        S_DN_CMP,
        S_PLACE,
        S_TOP,
        S_TOP_O
    } state_t;

endpackage

FILE: hdl/impq_ram.sv
// ----------------------------------------------------------------------------
// impq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module impq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/indexed_max_priority_queue_core.sv
// ----------------------------------------------------------------------------
// indexed_max_priority_queue_core
// Indexed binary max-heap with slot keys, heap order and reverse positions
// held in RAMs, walked by signed key compares under a small sequencer.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 word
// s_*       in   s_tvalid / s_tready       cmd, slot, key
// m_*       out  m_tvalid / m_tready       status, key_out, slot_out, size,
//                                          empty_res, top_slot, top_key
//
// each level of sift-up or sift-down costs RAM reads of the order and key
// stores through their single registered read ports, and a level of
// sift-down also reads the right child's key when that child exists.
// reset clears the count and the valid bits of the key and position stores.
// a new word is taken while the previous result waits in the output register;
// a stalled output holds the sequencer in its final state.
// ----------------------------------------------------------------------------
module indexed_max_priority_queue_core
    import impq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd[1:0], slot[7:2], key[39:8]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[2:0], key_out[34:3],
                                        // slot_out[40:35], size[47:41],
                                        // empty_res[48], top_slot[54:49],
                                        // top_key[86:55], zero pad[87]
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = ((AW > SLOT_W) ? AW : SLOT_W) + 1;

    state_t              state_reg, state_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [AW-1:0]       cur_slot_reg, cur_slot_next;
    logic [KEY_W-1:0]    cur_key_reg, cur_key_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                moved_reg, moved_next;
    logic [AW-1:0]       ch_slot_reg, ch_slot_next;
    logic [KEY_W-1:0]    ch_key_reg, ch_key_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [KEY_W-1:0]    key_out_reg, key_out_next;
    logic [AW-1:0]       slot_out_reg, slot_out_next;
    logic [AW-1:0]       top_slot_reg, top_slot_next;
    logic [KEY_W-1:0]    top_key_reg, top_key_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [CAPACITY-1:0] key_vld_reg, pos_vld_reg;
    logic                key_rv_reg, pos_rv_reg;

    // ram ports
    logic             key_we, ord_we, pos_we;
    logic [AW-1:0]    key_waddr, key_raddr, ord_waddr, ord_raddr, pos_waddr, pos_raddr;
    logic [KEY_W-1:0] key_wdata, key_rdata, key_rd;
    logic [AW-1:0]    ord_wdata, ord_rdata;
    logic [CW-1:0]    pos_wdata, pos_rdata, pos_rd;

    // input word fields
    logic [CMD_W-1:0]  in_cmd;
    logic [SLOT_W-1:0] in_slot;
    logic [KEY_W-1:0]  in_key;
    logic [CW:0]       k2;
    logic              in_acc;

    assign in_cmd  = s_tdata[1:0];
    assign in_slot = s_tdata[7:2];
    assign in_key  = s_tdata[39:8];
    assign in_acc  = s_tvalid && s_tready;
    assign k2      = {k_reg, 1'b0};

    // entries never written read as zero
    assign key_rd = key_rv_reg ? key_rdata : '0;
    assign pos_rd = pos_rv_reg ? pos_rdata : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    impq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(key_raddr), .rdata(key_rdata)
    );

    impq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_ord_ram (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    impq_ram #(.WIDTH(CW), .DEPTH(CAPACITY)) u_pos_ram (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata)
    );

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= CMD_INSERT;
            cur_slot_reg <= '0;
            cur_key_reg  <= '0;
            k_reg        <= '0;
            j_reg        <= '0;
            moved_reg    <= 1'b0;
            ch_slot_reg  <= '0;
            ch_key_reg   <= '0;
            status_reg   <= ST_OK;
            key_out_reg  <= '0;
            slot_out_reg <= '0;
            top_slot_reg <= '0;
            top_key_reg  <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            key_vld_reg  <= '0;
            pos_vld_reg  <= '0;
            key_rv_reg   <= 1'b0;
            pos_rv_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cmd_reg      <= cmd_next;
            cur_slot_reg <= cur_slot_next;
            cur_key_reg  <= cur_key_next;
            k_reg        <= k_next;
            j_reg        <= j_next;
            moved_reg    <= moved_next;
            ch_slot_reg  <= ch_slot_next;
            ch_key_reg   <= ch_key_next;
            status_reg   <= status_next;
            key_out_reg  <= key_out_next;
            slot_out_reg <= slot_out_next;
            top_slot_reg <= top_slot_next;
            top_key_reg  <= top_key_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            key_rv_reg   <= key_vld_reg[key_raddr];
            pos_rv_reg   <= pos_vld_reg[pos_raddr];
            if (key_we)
            begin
                key_vld_reg[key_waddr] <= 1'b1;
            end
            if (pos_we)
            begin
                pos_vld_reg[pos_waddr] <= 1'b1;
            end
        end
    end

    // sequencer: next state, ram controls and key compares
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        cur_slot_next = cur_slot_reg;
        cur_key_next  = cur_key_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        moved_next    = moved_reg;
        ch_slot_next  = ch_slot_reg;
        ch_key_next   = ch_key_reg;
        status_next   = status_reg;
        key_out_next  = key_out_reg;
        slot_out_next = slot_out_reg;
        top_slot_next = top_slot_reg;
        top_key_next  = top_key_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        key_we        = 1'b0;
        key_waddr     = cur_slot_reg;
        key_wdata     = cur_key_reg;
        key_raddr     = cur_slot_reg;
        ord_we        = 1'b0;
        ord_waddr     = AW'(k_reg - CW'(1));
        ord_wdata     = cur_slot_reg;
        ord_raddr     = '0;
        pos_we        = 1'b0;
        pos_waddr     = cur_slot_reg;
        pos_wdata     = k_reg;
        pos_raddr     = cur_slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                key_raddr = AW'(in_slot);
                pos_raddr = AW'(in_slot);
                if (in_acc)
                begin
                    cmd_next      = in_cmd;
                    cur_slot_next = AW'(in_slot);
                    cur_key_next  = in_key;
                    moved_next    = 1'b0;
                    status_next   = ST_OK;
                    key_out_next  = '0;
                    slot_out_next = '0;
                    top_slot_next = '0;
                    top_key_next  = '0;
                    if (in_cmd == CMD_EXTRACT)
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_TOP;
                        end
                        else
                        begin
                            state_next = S_EX_ORD;
                        end
                    end
                    else if (RW'(in_slot) >= RW'(CAPACITY))
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_TOP;
                    end
                    else
                    begin
                        state_next = S_POS;
                    end
                end
            end

            // slot lookup done: decide the command
            S_POS:
            begin
                if (cmd_reg == CMD_GET)
                begin
                    key_out_next = key_rd;
                    state_next   = S_TOP;
                end
                else if (cmd_reg == CMD_INSERT && pos_rd == '0)
                begin
                    if (cnt_reg == CW'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_TOP;
                    end
                    else
                    begin
                        key_we     = 1'b1;
                        cnt_next   = cnt_reg + CW'(1);
                        k_next     = cnt_reg + CW'(1);
                        state_next = S_UP;
                    end
                end
                else
                begin
                    // rekey, insert into an occupied slot included
                    if (cmd_reg == CMD_INSERT)
                    begin
                        status_next = ST_OCCUPIED;
                    end
                    key_we = 1'b1;
                    if (pos_rd != '0)
                    begin
                        k_next     = pos_rd;
                        state_next = S_UP;
                    end
                    else
                    begin
                        state_next = S_TOP;
                    end
                end
            end

            // extract: read top slot, then its key and the last slot
            S_EX_ORD:
            begin
                slot_out_next = ord_rdata;
                key_raddr     = ord_rdata;
                ord_raddr     = AW'(cnt_reg - CW'(1));
                state_next    = S_EX_KEY;
            end

            S_EX_KEY:
            begin
                key_out_next  = key_rd;
                pos_we        = 1'b1;
                pos_waddr     = slot_out_reg;
                pos_wdata     = '0;
                cnt_next      = cnt_reg - CW'(1);
                cur_slot_next = ord_rdata;
                key_raddr     = ord_rdata;
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_TOP;
                end
                else
                begin
                    state_next = S_EX_LK;
                end
            end

            S_EX_LK:
            begin
                cur_key_next = key_rd;
                k_next       = CW'(1);
                state_next   = S_DN;
            end

            // sift up: fetch parent slot
            S_UP:
            begin
                if (k_reg > CW'(1))
                begin
                    ord_raddr  = AW'((k_reg >> 1) - CW'(1));
                    state_next = S_UP_O;
                end
                else if (moved_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_DN;
                end
            end

            S_UP_O:
            begin
                ch_slot_next = ord_rdata;
                key_raddr    = ord_rdata;
                state_next   = S_UP_K;
            end

            // parent moves down when strictly smaller
            S_UP_K:
            begin
                if ($signed(key_rd) < $signed(cur_key_reg))
                begin
                    ord_we     = 1'b1;
                    ord_wdata  = ch_slot_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = ch_slot_reg;
                    k_next     = k_reg >> 1;
                    moved_next = 1'b1;
                    state_next = S_UP;
                end
                else if (moved_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_DN;
                end
            end

            // sift down: fetch children
            S_DN:
            begin
                if (k2 <= {1'b0, cnt_reg})
                begin
                    ord_raddr  = AW'(k2 - (CW + 1)'(1));
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_DN_L:
            begin
                ch_slot_next = ord_rdata;
                key_raddr    = ord_rdata;
                ord_raddr    = AW'(k2);
                state_next   = S_DN_LK;
            end

            S_DN_LK:
            begin
                ch_key_next = key_rd;
                j_next      = CW'(k2);
                if (k2 < {1'b0, cnt_reg})
                begin
                    cur_slot_next = cur_slot_reg;
                    key_raddr     = ord_rdata;
                    ch_slot_next  = ch_slot_reg;
                    top_slot_next = ord_rdata;
                    state_next    = S_DN_RK;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            // right child wins only when strictly greater
            S_DN_RK:
            begin
                top_slot_next = '0;
                if ($signed(key_rd) > $signed(ch_key_reg))
                begin
                    ch_key_next  = key_rd;
                    ch_slot_next = top_slot_reg;
                    j_next       = j_reg + CW'(1);
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                if ($signed(cur_key_reg) >= $signed(ch_key_reg))
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ord_we     = 1'b1;
                    ord_wdata  = ch_slot_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = ch_slot_reg;
                    k_next     = j_reg;
                    state_next = S_DN;
                end
            end

            // moving entry lands at its final position
            S_PLACE:
            begin
                ord_we     = 1'b1;
                pos_we     = 1'b1;
                state_next = S_TOP;
            end

            // top of heap for the result
            S_TOP:
            begin
                moved_next = 1'b0;
                if (cnt_reg == '0)
                begin
                    state_next = S_TOP_O;
                end
                else
                begin
                    ord_raddr  = '0;
                    state_next = S_TOP_O;
                end
            end

            S_TOP_O:
            begin
                if (top_key_reg == '0 && !moved_reg && cnt_reg != '0 && !m_tvalid_reg)
                begin
                    top_slot_next = top_slot_reg;
                end
                if (cnt_reg != '0 && !key_we)
                begin
                    key_raddr = ord_rdata;
                end
                cmd_next   = cmd_reg;
                state_next = S_TOP_O;
                moved_next = 1'b1;
                if (moved_reg || cnt_reg == '0)
                begin
                    moved_next = moved_reg;
                end
                // a non-empty heap has its top slot captured and key read issued before the word loads
                if (!moved_reg && cnt_reg != '0)
                begin
                    top_slot_next = ord_rdata;
                end
                else if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0,
                                     (cnt_reg == '0) ? KEY_W'(0) : key_rd,
                                     (cnt_reg == '0) ? SLOT_W'(0) : SLOT_W'(top_slot_reg),
                                     (cnt_reg == '0),
                                     SIZE_W'(cnt_reg),
                                     SLOT_W'(slot_out_reg),
                                     key_out_reg,
                                     status_reg};
                    moved_next    = 1'b0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    key_raddr = top_slot_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // heap never holds more than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // an accepted word always starts a command
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg != S_IDLE)
        else $error("accepted word not started");

    // sift position stays inside the heap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP || state_reg == S_DN) |-> (k_reg != '0 && k_reg <= cnt_reg))
        else $error("sift position out of heap");

    // empty flag agrees with size in every result word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[48] == (m_tdata[47:41] == '0)))
        else $error("empty flag mismatch");

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the indexed max priority queue core: commands go in
// through the input stream, a local heap model predicts each result word and
// a monitor compares every output word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import impq_pkg::*;

    localparam int CAP = 64;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    indexed_max_priority_queue_core #(.CAPACITY(CAP)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key_out;
        logic [SLOT_W-1:0]   slot_out;
        logic [SIZE_W-1:0]   size;
        logic                empty_res;
        logic [SLOT_W-1:0]   top_slot;
        logic [KEY_W-1:0]    top_key;
    } heap_result_t;

    // model of the heap
    logic [KEY_W-1:0] mdl_key [CAP];
    logic [5:0]       mdl_order [CAP];
    int               mdl_pos [CAP];
    int               mdl_count;

    heap_result_t expected_q[$];
    int  err_count;
    bit  quiet_in;
    bit  quiet_out;

    // clock
    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    function automatic logic signed [KEY_W-1:0] key_at(int p);
        return mdl_key[mdl_order[p-1]];
    endfunction

    function automatic void swap_heap(int a, int b);
        logic [5:0] sa, sb;
        sa = mdl_order[a-1];
        sb = mdl_order[b-1];
        mdl_order[a-1] = sb;
        mdl_order[b-1] = sa;
        mdl_pos[sa] = b;
        mdl_pos[sb] = a;
    endfunction

    function automatic void heap_up(int k);
        while (k > 1 && key_at(k/2) < key_at(k))
        begin
            swap_heap(k/2, k);
            k = k/2;
        end
    endfunction

    function automatic void heap_down(int k);
        int j;
        while (2*k <= mdl_count)
        begin
            j = 2*k;
            if (j+1 <= mdl_count && key_at(j+1) > key_at(j))
                j = j+1;
            if (key_at(k) >= key_at(j))
                break;
            swap_heap(k, j);
            k = j;
        end
    endfunction

    function automatic void rekey(int s, logic [KEY_W-1:0] k);
        int p;
        mdl_key[s] = k;
        p = mdl_pos[s];
        if (p >= 1 && p <= mdl_count)
        begin
            heap_up(p);
            heap_down(p);
        end
    endfunction

    function automatic heap_result_t heap_predict(logic [CMD_W-1:0] cmd, logic [5:0] slot,
                                                  logic [KEY_W-1:0] k);
        heap_result_t r;
        logic [5:0] s;
        r = '0;
        r.status = ST_OK;
        if (cmd == CMD_EXTRACT)
        begin
            if (mdl_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                s = mdl_order[0];
                r.key_out = mdl_key[s];
                r.slot_out = s;
                swap_heap(1, mdl_count);
                mdl_pos[s] = 0;
                mdl_count--;
                heap_down(1);
            end
        end
        else if (cmd == CMD_INSERT)
        begin
            if (mdl_pos[slot] != 0)
            begin
                r.status = ST_OCCUPIED;
                rekey(slot, k);
            end
            else if (mdl_count >= CAP)
                r.status = ST_FULL;
            else
            begin
                mdl_key[slot] = k;
                mdl_count++;
                mdl_order[mdl_count-1] = slot;
                mdl_pos[slot] = mdl_count;
                heap_up(mdl_count);
            end
        end
        else if (cmd == CMD_CHANGE)
            rekey(slot, k);
        else
            r.key_out = mdl_key[slot];
        r.size = mdl_count[SIZE_W-1:0];
        r.empty_res = (mdl_count == 0);
        if (mdl_count > 0)
        begin
            r.top_slot = mdl_order[0];
            r.top_key = mdl_key[mdl_order[0]];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
        err_count++;
    endtask

    // send one command word
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [5:0] slot, logic [KEY_W-1:0] k);
        while (!quiet_in && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_W'({$urandom, $urandom});
            @(posedge clk);
        end
        expected_q.push_back(heap_predict(cmd, slot, k));
        s_tvalid <= 1'b1;
        s_tdata  <= {k, slot, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // output stall pattern
    always @(posedge clk)
        m_tready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 30);

    // result monitor
    always @(posedge clk)
    begin
        heap_result_t got, exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[2:0], m_tdata[34:3], m_tdata[40:35], m_tdata[47:41],
                   m_tdata[48], m_tdata[54:49], m_tdata[86:55]};
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected word", got.key_out, '0);
            end
            else
            begin
                exp = expected_q.pop_front();
                if (got.status !== exp.status)       report_mismatch("status", got.status, exp.status);
                if (got.key_out !== exp.key_out)     report_mismatch("key_out", got.key_out, exp.key_out);
                if (got.slot_out !== exp.slot_out)   report_mismatch("slot_out", got.slot_out, exp.slot_out);
                if (got.size !== exp.size)           report_mismatch("size", got.size, exp.size);
                if (got.empty_res !== exp.empty_res) report_mismatch("empty_res", got.empty_res, exp.empty_res);
                if (got.top_slot !== exp.top_slot)   report_mismatch("top_slot", got.top_slot, exp.top_slot);
                if (got.top_key !== exp.top_key)     report_mismatch("top_key", got.top_key, exp.top_key);
            end
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7);
            3: return 32'hffff_fff0 | $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_cmd(CMD_EXTRACT, 6'd0, 32'h0);          // empty extract
        send_cmd(CMD_GET, 6'd63, 32'hffff_ffff);     // untouched key reads zero
        send_cmd(CMD_CHANGE, 6'd5, 32'h1234_5678);   // change of absent slot
        send_cmd(CMD_GET, 6'd5, 32'h0);
        send_cmd(CMD_INSERT, 6'd0, 32'h8000_0000);
        send_cmd(CMD_INSERT, 6'd63, 32'h7fff_ffff);
        send_cmd(CMD_INSERT, 6'd7, 32'hffff_ffff);
        send_cmd(CMD_INSERT, 6'd8, 32'hffff_ffff);   // equal keys, strict order
        send_cmd(CMD_INSERT, 6'd7, 32'h0000_0001);   // occupied slot repair
        send_cmd(CMD_CHANGE, 6'd0, 32'h7fff_ffff);
        send_cmd(CMD_CHANGE, 6'd63, 32'h8000_0000);
        send_cmd(CMD_GET, 6'd63, 32'h0);
        repeat (5) send_cmd(CMD_EXTRACT, 6'd0, 32'h0);
        send_cmd(CMD_GET, 6'd0, 32'h0);
    endtask

    task automatic test_fill();
        // fill to capacity, then rekey through an occupied insert
        for (int i = 0; i < CAP; i++)
            send_cmd(CMD_INSERT, i[5:0], rand_key());
        send_cmd(CMD_INSERT, 6'd3, 32'h55);
        send_cmd(CMD_EXTRACT, 6'd0, 32'h0);
        send_cmd(CMD_INSERT, 6'd1, 32'h0);
        for (int i = 0; i < CAP + 1; i++)
            send_cmd(CMD_EXTRACT, 6'd0, 32'h0);
    endtask

    task automatic test_random(int n);
        logic [CMD_W-1:0] c;
        for (int i = 0; i < n; i++)
        begin
            quiet_in  = (i > n/2 && i < n/2 + 150);
            quiet_out = quiet_in;
            case ($urandom_range(9))
                0, 1, 2, 3: c = CMD_INSERT;
                4, 5:       c = CMD_EXTRACT;
                6, 7:       c = CMD_CHANGE;
                default:    c = CMD_GET;
            endcase
            send_cmd(c, 6'($urandom_range(63)), rand_key());
        end
        quiet_in = 0;
        quiet_out = 0;
    endtask

    initial
    begin
        for (int i = 0; i < CAP; i++)
        begin
            mdl_key[i] = '0;
            mdl_order[i] = '0;
            mdl_pos[i] = 0;
        end
        mdl_count = 0;
        err_count = 0;
        quiet_in = 0;
        quiet_out = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill();
        test_random(1130);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: sim.f
hdl/impq_pkg.sv
hdl/impq_ram.sv
hdl/indexed_max_priority_queue_core.sv
sim/testbench.sv
